// File: src/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, phase counts and the pin pattern of every command phase.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned PHASE_W = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEND  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WAIT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_ACK   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NACK  = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_LIMIT  = 1'd1;

  localparam logic [BYTE_W-1:0] HOLD_TICKS_RST = 8'd1;
  localparam logic [BYTE_W-1:0] ACK_LIMIT_RST  = 8'd250;

  localparam logic [PHASE_W-1:0] SEND_PHASES  = 5'd17;
  localparam logic [PHASE_W-1:0] READ_PHASES  = 5'd19;
  localparam logic [PHASE_W-1:0] WAIT_PHASES  = 5'd4;
  localparam logic [PHASE_W-1:0] SHORT_PHASES = 5'd3;
  localparam logic [PHASE_W-1:0] WAIT_POLL_PHASE = 5'd2;
  localparam logic [PHASE_W-1:0] WAIT_DONE_PHASE = 5'd3;
  localparam logic [PHASE_W-1:0] BIT_PHASES   = 5'd16;
  localparam logic [PHASE_W-1:0] LAST_BIT_PHASE = 5'd15;
  localparam logic [PHASE_W-1:0] READ_ACK_HIGH  = 5'd17;

  typedef struct packed {
    logic drv;
    logic sda;
    logic scl;
  } pins_t;

  localparam pins_t PINS_IDLE = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};

  function automatic logic [PHASE_W-1:0] phase_total(input logic [CMD_W-1:0] cmd);
    logic [PHASE_W-1:0] total;
    case (cmd)
      CMD_SEND: total = SEND_PHASES;
      CMD_READ: total = READ_PHASES;
      CMD_WAIT: total = WAIT_PHASES;
      default:  total = SHORT_PHASES;
    endcase
    return total;
  endfunction

  function automatic pins_t phase_pins(input logic [CMD_W-1:0] cmd,
                                       input logic [PHASE_W-1:0] p,
                                       input logic [BYTE_W-1:0] shift,
                                       input logic ack);
    pins_t pins;
    pins = PINS_IDLE;
    case (cmd)
      CMD_START: begin
        pins.scl = (p < 5'd2);
        pins.sda = (p == 5'd0);
        pins.drv = 1'b1;
      end
      CMD_STOP: begin
        pins.scl = (p != 5'd0);
        pins.sda = (p == 5'd2);
        pins.drv = 1'b1;
      end
      CMD_ACK, CMD_NACK: begin
        pins.scl = (p == 5'd1);
        pins.sda = (cmd == CMD_NACK);
        pins.drv = 1'b1;
      end
      CMD_SEND: begin
        pins.drv = 1'b1;
        if (p < BIT_PHASES) begin
          pins.scl = p[0];
          pins.sda = shift[~p[3:1]];
        end else begin
          pins.scl = 1'b0;
          pins.sda = shift[0];
        end
      end
      CMD_READ: begin
        if (p < BIT_PHASES) begin
          pins.scl = p[0];
          pins.sda = 1'b1;
          pins.drv = 1'b0;
        end else begin
          pins.scl = (p == READ_ACK_HIGH);
          pins.sda = ~ack;
          pins.drv = 1'b1;
        end
      end
      CMD_WAIT: begin
        pins.scl = (p == 5'd1) || (p == 5'd2);
        pins.sda = 1'b1;
        pins.drv = 1'b0;
      end
      default: pins = PINS_IDLE;
    endcase
    return pins;
  endfunction

endpackage

// File: src/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Each input transaction is one timing tick; the engine runs start, stop,
// send, wait-ack, read, ack and nack as sequences of pin phases and returns
// one result transaction per tick.
// ----------------------------------------------------------------------------
// The block takes one tick transaction per clock cycle and answers each with
// one result transaction that holds the pin levels and status after that
// tick; a tick is processed in the cycle it is accepted and its result sits
// in an output register, so a new tick can enter in every cycle while the
// result side keeps up. Write hold_ticks and ack_limit only while no command
// is running and no result is pending.
module i2c_master_bit_engine
  import i2cmbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_kind,
  input  logic [BYTE_W-1:0]    in_tx_byte,
  input  logic                 in_ack_after_read,
  input  logic                 in_sda_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_scl_level,
  output logic                 out_sda_level,
  output logic                 out_sda_drive,
  output logic                 out_busy_res,
  output logic                 out_done_res,
  output logic [BYTE_W-1:0]    out_rx_byte,
  output logic                 out_ack_error,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  logic [BYTE_W-1:0]  hold_ticks_r;
  logic [BYTE_W-1:0]  ack_limit_r;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [BYTE_W-1:0]  hold_cnt_r, hold_cnt_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [BYTE_W-1:0]  wait_cnt_r, wait_cnt_nxt;
  pins_t              pins_r, pins_nxt;
  logic               err_r, err_nxt;
  logic [BYTE_W-1:0]  rx_r, rx_nxt;
  logic               ack_r, ack_nxt;
  logic               done_nxt;
  logic               enter;
  logic [BYTE_W-1:0]  hold;
  logic [BYTE_W-1:0]  shifted;
  logic               in_accept;
  logic               out_valid_r;
  logic               busy_out_r, done_out_r, err_out_r;
  logic [BYTE_W-1:0]  rx_out_r;
  pins_t              pins_out_r;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign hold      = (hold_ticks_r == '0) ? HOLD_TICKS_RST : hold_ticks_r;
  assign shifted   = {shift_r[BYTE_W-2:0], in_sda_sample};

  always_comb begin
    cmd_nxt      = cmd_r;
    phase_nxt    = phase_r;
    hold_cnt_nxt = hold_cnt_r;
    shift_nxt    = shift_r;
    wait_cnt_nxt = wait_cnt_r;
    err_nxt      = err_r;
    rx_nxt       = rx_r;
    ack_nxt      = ack_r;
    done_nxt     = 1'b0;
    enter        = 1'b0;
    if (cmd_r == CMD_NONE) begin
      if (in_kind != CMD_NONE) begin
        shift_nxt    = (in_kind == CMD_SEND) ? in_tx_byte : '0;
        wait_cnt_nxt = '0;
        if (in_kind == CMD_READ) begin
          ack_nxt = in_ack_after_read;
        end
        if (in_kind == CMD_WAIT) begin
          err_nxt = 1'b0;
        end
        cmd_nxt   = in_kind;
        phase_nxt = '0;
        enter     = 1'b1;
      end
    end else if (cmd_r == CMD_WAIT && phase_r == WAIT_POLL_PHASE) begin
      if (!in_sda_sample) begin
        phase_nxt = WAIT_DONE_PHASE;
        enter     = 1'b1;
      end else if (wait_cnt_r >= ack_limit_r) begin
        err_nxt   = 1'b1;
        cmd_nxt   = CMD_STOP;
        phase_nxt = '0;
        enter     = 1'b1;
      end else begin
        wait_cnt_nxt = wait_cnt_r + 8'd1;
      end
    end else if (hold_cnt_r < hold) begin
      hold_cnt_nxt = hold_cnt_r + 8'd1;
    end else begin
      if (cmd_r == CMD_READ && phase_r < BIT_PHASES && phase_r[0]) begin
        shift_nxt = shifted;
        if (phase_r == LAST_BIT_PHASE) begin
          rx_nxt = shifted;
        end
      end
      if (phase_r + 5'd1 < phase_total(cmd_r)) begin
        phase_nxt = phase_r + 5'd1;
        enter     = 1'b1;
      end else begin
        cmd_nxt      = CMD_NONE;
        phase_nxt    = '0;
        hold_cnt_nxt = '0;
        done_nxt     = 1'b1;
      end
    end
    if (enter) begin
      hold_cnt_nxt = 8'd1;
      pins_nxt     = phase_pins(cmd_nxt, phase_nxt, shift_nxt, ack_nxt);
    end else begin
      pins_nxt = pins_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r <= HOLD_TICKS_RST;
      ack_limit_r  <= ACK_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOLD_TICKS: hold_ticks_r <= cfg_data;
        REG_ACK_LIMIT:  ack_limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r      <= CMD_NONE;
      phase_r    <= '0;
      hold_cnt_r <= '0;
      shift_r    <= '0;
      wait_cnt_r <= '0;
      pins_r     <= PINS_IDLE;
      err_r      <= 1'b0;
      rx_r       <= '0;
      ack_r      <= 1'b0;
    end else if (in_accept) begin
      cmd_r      <= cmd_nxt;
      phase_r    <= phase_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      shift_r    <= shift_nxt;
      wait_cnt_r <= wait_cnt_nxt;
      pins_r     <= pins_nxt;
      err_r      <= err_nxt;
      rx_r       <= rx_nxt;
      ack_r      <= ack_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pins_out_r <= pins_nxt;
      busy_out_r <= (cmd_nxt != CMD_NONE);
      done_out_r <= done_nxt;
      rx_out_r   <= rx_nxt;
      err_out_r  <= err_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_level = pins_out_r.scl;
  assign out_sda_level = pins_out_r.sda;
  assign out_sda_drive = pins_out_r.drv;
  assign out_busy_res  = busy_out_r;
  assign out_done_res  = done_out_r;
  assign out_rx_byte   = rx_out_r;
  assign out_ack_error = err_out_r;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives timing ticks with optional commands into the engine. A cycle-level
// model of the command phases predicts each result transaction, and every
// result is compared field by field. Directed tests cover every command, the
// busy and timeout cases and the extreme register values. Random command
// sequences then run under several idle patterns.
// ----------------------------------------------------------------------------
module tb;
  import i2cmbe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [CMD_W-1:0]  kind;
    logic [BYTE_W-1:0] tx;
    logic              ack;
    logic              sda;
  } tick_t;

  typedef struct {
    logic              scl;
    logic              sda;
    logic              drv;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rx;
    logic              err;
  } bus_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_kind = CMD_NONE;
  logic [BYTE_W-1:0]    in_tx_byte = '0;
  logic                 in_ack_after_read = 1'b0;
  logic                 in_sda_sample = 1'b1;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_scl_level;
  logic                 out_sda_level;
  logic                 out_sda_drive;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [BYTE_W-1:0]    out_rx_byte;
  logic                 out_ack_error;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HOLD_TICKS;
  logic [BYTE_W-1:0]    cfg_data = '0;

  i2c_master_bit_engine dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_tx_byte        (in_tx_byte),
    .in_ack_after_read (in_ack_after_read),
    .in_sda_sample     (in_sda_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scl_level     (out_scl_level),
    .out_sda_level     (out_sda_level),
    .out_sda_drive     (out_sda_drive),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_rx_byte       (out_rx_byte),
    .out_ack_error     (out_ack_error),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned cycles = 0;
  int          errors = 0;

  bus_result_t expected_q[$];
  tick_t       cmd_script[$];
  logic        wait_nak = 1'b0;

  logic [BYTE_W-1:0] cfg_hold = HOLD_TICKS_RST;
  logic [BYTE_W-1:0] cfg_limit = ACK_LIMIT_RST;
  logic [CMD_W-1:0]  bus_cmd = CMD_NONE;
  logic [5:0]        bus_phase = '0;
  logic [BYTE_W-1:0] hold_cnt = '0;
  logic [BYTE_W-1:0] shift_q = '0;
  logic [BYTE_W-1:0] poll_cnt = '0;
  logic [BYTE_W-1:0] rx_last = '0;
  logic              read_ack = 1'b0;
  logic              ack_err = 1'b0;
  pins_t             pins = PINS_IDLE;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall = rst_n && ($urandom_range(99) < sink_stall_pct);
  end

  function automatic int phase_count(logic [CMD_W-1:0] c);
    case (c)
      CMD_SEND: return 17;
      CMD_READ: return 19;
      CMD_WAIT: return 4;
      default:  return 3;
    endcase
  endfunction

  function automatic void set_pins(logic scl, logic sda, logic drv);
    pins.scl = scl;
    pins.sda = drv ? sda : 1'b1;
    pins.drv = drv;
  endfunction

  function automatic void enter_phase(logic [CMD_W-1:0] c, logic [5:0] p);
    bus_cmd = c;
    bus_phase = p;
    hold_cnt = 8'd1;
    case (c)
      CMD_START: set_pins(p < 2, p == 0, 1'b1);
      CMD_STOP: set_pins(p != 0, p == 2, 1'b1);
      CMD_ACK, CMD_NACK: set_pins(p == 1, c == CMD_NACK, 1'b1);
      CMD_SEND: begin
        if (p < BIT_PHASES) set_pins(p[0], shift_q[7 - p[3:1]], 1'b1);
        else set_pins(1'b0, shift_q[0], 1'b1);
      end
      CMD_READ: begin
        if (p < BIT_PHASES) set_pins(p[0], 1'b1, 1'b0);
        else set_pins(p == READ_ACK_HIGH, !read_ack, 1'b1);
      end
      CMD_WAIT: set_pins(p == 1 || p == 2, 1'b1, 1'b0);
      default: ;
    endcase
  endfunction

  function automatic void predict_tick(tick_t t);
    int unsigned hold;
    bus_result_t r;
    hold = (cfg_hold == 0) ? 1 : cfg_hold;
    r.done = 1'b0;
    if (bus_cmd == CMD_NONE) begin
      if (t.kind != CMD_NONE) begin
        shift_q = '0;
        poll_cnt = '0;
        if (t.kind == CMD_SEND) shift_q = t.tx;
        if (t.kind == CMD_READ) read_ack = t.ack;
        if (t.kind == CMD_WAIT) ack_err = 1'b0;
        enter_phase(t.kind, 6'd0);
      end
    end else if (bus_cmd == CMD_WAIT && bus_phase == WAIT_POLL_PHASE) begin
      if (!t.sda) begin
        enter_phase(CMD_WAIT, 6'(WAIT_DONE_PHASE));
      end else if (poll_cnt >= cfg_limit) begin
        ack_err = 1'b1;
        enter_phase(CMD_STOP, 6'd0);
      end else begin
        poll_cnt++;
      end
    end else if (hold_cnt < hold) begin
      hold_cnt++;
    end else begin
      if (bus_cmd == CMD_READ && bus_phase < BIT_PHASES && bus_phase[0]) begin
        shift_q = {shift_q[6:0], t.sda};
        if (bus_phase == LAST_BIT_PHASE) rx_last = shift_q;
      end
      if (bus_phase + 1 < phase_count(bus_cmd)) begin
        enter_phase(bus_cmd, bus_phase + 6'd1);
      end else begin
        bus_cmd = CMD_NONE;
        bus_phase = '0;
        hold_cnt = '0;
        r.done = 1'b1;
      end
    end
    r.scl = pins.scl;
    r.sda = pins.sda;
    r.drv = pins.drv;
    r.busy = (bus_cmd != CMD_NONE);
    r.rx = rx_last;
    r.err = ack_err;
    expected_q.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [7:0] exp, logic [7:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, actual %0h", name, exp, act);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    bus_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with no expected result");
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("scl_level", 8'(e.scl), 8'(out_scl_level));
        check_field("sda_level", 8'(e.sda), 8'(out_sda_level));
        check_field("sda_drive", 8'(e.drv), 8'(out_sda_drive));
        check_field("busy_res", 8'(e.busy), 8'(out_busy_res));
        check_field("done_res", 8'(e.done), 8'(out_done_res));
        check_field("rx_byte", e.rx, out_rx_byte);
        check_field("ack_error", 8'(e.err), 8'(out_ack_error));
      end
    end
  end

  function automatic tick_t make_tick(logic [CMD_W-1:0] kind, logic [BYTE_W-1:0] tx,
                                      logic ack, logic sda);
    tick_t t;
    t.kind = kind;
    t.tx = tx;
    t.ack = ack;
    t.sda = sda;
    return t;
  endfunction

  function automatic tick_t rand_cmd(logic [CMD_W-1:0] kind);
    return make_tick(kind, 8'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  task automatic send_tick(tick_t t);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < src_idle_pct) gap++;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = t.kind;
    in_tx_byte = t.tx;
    in_ack_after_read = t.ack;
    in_sda_sample = t.sda;
    do @(posedge clk); while (in_stall);
    predict_tick(t);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic settle_engine();
    while (bus_cmd != CMD_NONE) send_tick(rand_cmd(CMD_NONE));
    drain_results();
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
    settle_engine();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_HOLD_TICKS) cfg_hold = data;
    else cfg_limit = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_cmd(logic [CMD_W-1:0] kind, logic [BYTE_W-1:0] tx, logic ack,
                         logic sda);
    send_tick(make_tick(kind, tx, ack, sda));
    while (bus_cmd != CMD_NONE) send_tick(make_tick(CMD_NONE, '0, 1'b0, sda));
  endtask

  function automatic void build_script();
    int unsigned n;
    cmd_script.push_back(rand_cmd(CMD_START));
    cmd_script.push_back(rand_cmd(CMD_SEND));
    cmd_script.push_back(rand_cmd(CMD_WAIT));
    n = $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(3))
        0: begin
          cmd_script.push_back(rand_cmd(CMD_SEND));
          cmd_script.push_back(rand_cmd(CMD_WAIT));
        end
        1, 2: cmd_script.push_back(rand_cmd(CMD_READ));
        default: begin
          cmd_script.push_back(rand_cmd($urandom_range(1) ? CMD_ACK : CMD_NACK));
        end
      endcase
    end
    cmd_script.push_back(rand_cmd(CMD_STOP));
  endfunction

  task automatic random_tick();
    tick_t t;
    t = rand_cmd(3'($urandom_range(7)));
    if (bus_cmd == CMD_NONE) begin
      if ($urandom_range(99) < 88) begin
        if (cmd_script.size() == 0) build_script();
        t = cmd_script.pop_front();
      end
      if (t.kind == CMD_WAIT) wait_nak = ($urandom_range(99) < 15);
    end else if (bus_cmd == CMD_WAIT && bus_phase == WAIT_POLL_PHASE) begin
      t.sda = wait_nak || ($urandom_range(99) < 60);
    end
    send_tick(t);
  endtask

  task automatic test_reset_values();
    send_tick(make_tick(CMD_NONE, 8'hFF, 1'b1, 1'b0));
    drain_results();
  endtask

  task automatic test_each_command();
    run_cmd(CMD_START, '0, 1'b0, 1'b1);
    run_cmd(CMD_SEND, 8'hFF, 1'b0, 1'b1);
    run_cmd(CMD_WAIT, '0, 1'b0, 1'b0);
    run_cmd(CMD_SEND, 8'h00, 1'b1, 1'b0);
    run_cmd(CMD_WAIT, '0, 1'b0, 1'b0);
    run_cmd(CMD_READ, '0, 1'b1, 1'b1);
    run_cmd(CMD_READ, '0, 1'b0, 1'b0);
    run_cmd(CMD_ACK, '0, 1'b0, 1'b1);
    run_cmd(CMD_NACK, '0, 1'b0, 1'b1);
    run_cmd(CMD_STOP, '0, 1'b0, 1'b1);
  endtask

  task automatic test_busy_commands();
    send_tick(make_tick(CMD_START, '0, 1'b0, 1'b1));
    while (bus_cmd != CMD_NONE) send_tick(make_tick(CMD_STOP, 8'hFF, 1'b1, 1'b1));
    run_cmd(CMD_SEND, 8'hA5, 1'b0, 1'b1);
  endtask

  task automatic test_ack_timeout();
    write_reg(REG_ACK_LIMIT, 8'd0);
    run_cmd(CMD_WAIT, '0, 1'b0, 1'b1);
    run_cmd(CMD_WAIT, '0, 1'b0, 1'b0);
    write_reg(REG_ACK_LIMIT, 8'd255);
    run_cmd(CMD_WAIT, '0, 1'b0, 1'b1);
    write_reg(REG_ACK_LIMIT, ACK_LIMIT_RST);
  endtask

  task automatic test_hold_extremes();
    write_reg(REG_HOLD_TICKS, 8'd0);
    run_cmd(CMD_START, '0, 1'b0, 1'b1);
    run_cmd(CMD_SEND, 8'h5A, 1'b0, 1'b1);
    write_reg(REG_HOLD_TICKS, 8'd255);
    run_cmd(CMD_START, '0, 1'b0, 1'b1);
    write_reg(REG_HOLD_TICKS, HOLD_TICKS_RST);
  endtask

  task automatic test_random(int unsigned n, int unsigned src_pct, int unsigned sink_pct,
                             logic [BYTE_W-1:0] hold, logic [BYTE_W-1:0] limit);
    write_reg(REG_HOLD_TICKS, hold);
    write_reg(REG_ACK_LIMIT, limit);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    repeat (n / 2) random_tick();
    drain_results();
    repeat (n - n / 2) random_tick();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_reset_values();
    test_each_command();
    test_busy_commands();
    test_ack_timeout();
    test_hold_extremes();
    test_random(50, 38, 80, 8'd1, 8'd3);
    test_random(40, 38, 80, 8'd2, 8'd0);
    test_random(50, 80, 38, 8'd0, 8'd255);
    test_random(40, 80, 38, 8'd3, 8'd1);
    test_random(50, 0, 0, 8'd1, 8'd250);
    test_random(40, 0, 0, 8'd4, 8'd2);
    settle_engine();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/i2cmbe_pkg.sv
src/i2c_master_bit_engine.sv
tb/tb.sv
